@@ design/rrft_pkg.sv @@
package rrft_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned ROT_W    = 18;
   localparam int unsigned ROW_W    = 3 * ROT_W;
   localparam int unsigned OPND_W   = DATA_W + 1;
   localparam int unsigned PROD_W   = OPND_W + ROT_W;
   localparam int unsigned ACC_W    = PROD_W + 3;
   localparam int unsigned QUOT_W   = ACC_W - FRAC_W;
   localparam int unsigned CSR_DW   = 64;
   localparam int unsigned CSR_AW   = 6;
   localparam int unsigned TDATA_W  = 6 * DATA_W;

   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);
   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [ROW_W-1:0] ROT_ROW0_RESET = ROW_W'(65536);
   localparam logic [ROW_W-1:0] ROT_ROW1_RESET = ROW_W'(65536) << ROT_W;
   localparam logic [ROW_W-1:0] ROT_ROW2_RESET = ROW_W'(65536) << (2 * ROT_W);

   typedef enum logic [2:0] {
      REG_ROT_ROW0 = 3'd0,
      REG_ROT_ROW1 = 3'd1,
      REG_ROT_ROW2 = 3'd2,
      REG_OFFSET_X = 3'd3,
      REG_OFFSET_Y = 3'd4,
      REG_OFFSET_Z = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [2:0][ROW_W-1:0]  rot_row;
      logic [2:0][DATA_W-1:0] offset;
   } cfg_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

@@ design/rrft_csr.sv @@
module rrft_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [rrft_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [rrft_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [rrft_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready,
   output rrft_pkg::cfg_type            cfg
);

   rrft_pkg::cfg_type cfg_ff;
   rrft_pkg::cfg_type cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index      = csr_paddr[rrft_pkg::CSR_AW-1:3];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            rrft_pkg::REG_ROT_ROW0: cfg_in.rot_row[0] = csr_pwdata[rrft_pkg::ROW_W-1:0];
            rrft_pkg::REG_ROT_ROW1: cfg_in.rot_row[1] = csr_pwdata[rrft_pkg::ROW_W-1:0];
            rrft_pkg::REG_ROT_ROW2: cfg_in.rot_row[2] = csr_pwdata[rrft_pkg::ROW_W-1:0];
            rrft_pkg::REG_OFFSET_X: cfg_in.offset[0] = csr_pwdata[rrft_pkg::DATA_W-1:0];
            rrft_pkg::REG_OFFSET_Y: cfg_in.offset[1] = csr_pwdata[rrft_pkg::DATA_W-1:0];
            rrft_pkg::REG_OFFSET_Z: cfg_in.offset[2] = csr_pwdata[rrft_pkg::DATA_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         rrft_pkg::REG_ROT_ROW0: csr_prdata = rrft_pkg::CSR_DW'(cfg_ff.rot_row[0]);
         rrft_pkg::REG_ROT_ROW1: csr_prdata = rrft_pkg::CSR_DW'(cfg_ff.rot_row[1]);
         rrft_pkg::REG_ROT_ROW2: csr_prdata = rrft_pkg::CSR_DW'(cfg_ff.rot_row[2]);
         rrft_pkg::REG_OFFSET_X: csr_prdata = rrft_pkg::CSR_DW'(cfg_ff.offset[0]);
         rrft_pkg::REG_OFFSET_Y: csr_prdata = rrft_pkg::CSR_DW'(cfg_ff.offset[1]);
         rrft_pkg::REG_OFFSET_Z: csr_prdata = rrft_pkg::CSR_DW'(cfg_ff.offset[2]);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_row[0] <= rrft_pkg::ROT_ROW0_RESET;
         cfg_ff.rot_row[1] <= rrft_pkg::ROT_ROW1_RESET;
         cfg_ff.rot_row[2] <= rrft_pkg::ROT_ROW2_RESET;
         cfg_ff.offset     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/rrft_lane.sv @@
module rrft_lane (
   input  logic                                  clock,
   input  rrft_pkg::stage_en_type                en,
   input  logic [2:0][rrft_pkg::OPND_W-1:0]      opnd,
   input  logic [2:0][rrft_pkg::ROT_W-1:0]       coef,
   input  logic [rrft_pkg::DATA_W-1:0]           add_term,
   output logic [rrft_pkg::DATA_W-1:0]           result,
   output logic                                  sat
);

   localparam int unsigned PW = rrft_pkg::PROD_W;
   localparam int unsigned AW = rrft_pkg::ACC_W;
   localparam int unsigned DW = rrft_pkg::DATA_W;
   localparam int unsigned OW = rrft_pkg::OPND_W;
   localparam int unsigned RW = rrft_pkg::ROT_W;
   localparam int unsigned QW = rrft_pkg::QUOT_W;
   localparam int unsigned FW = rrft_pkg::FRAC_W;

   logic [2:0][PW-1:0] prod_ff;
   logic [2:0][PW-1:0] prod_in;
   logic [DW-1:0]      add1_ff;
   logic [AW-1:0]      sum_ff;
   logic [AW-1:0]      sum_in;
   logic [DW-1:0]      result_ff;
   logic [DW-1:0]      result_in;
   logic               sat_ff;
   logic               sat_in;
   logic [QW-1:0]      quot;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         prod_in[k] = PW'($signed({{(PW-OW){opnd[k][OW-1]}}, opnd[k]})
                        * $signed({{(PW-RW){coef[k][RW-1]}}, coef[k]}));
      end
   end

   always_comb begin
      sum_in = {{(AW-PW){prod_ff[0][PW-1]}}, prod_ff[0]}
             + {{(AW-PW){prod_ff[1][PW-1]}}, prod_ff[1]}
             + {{(AW-PW){prod_ff[2][PW-1]}}, prod_ff[2]}
             + {{(AW-DW-FW){add1_ff[DW-1]}}, add1_ff, {FW{1'b0}}}
             + rrft_pkg::ROUND_HALF;
   end

   assign quot = sum_ff[AW-1:FW];

   always_comb begin
      sat_in    = !((&quot[QW-1:DW-1]) || !(|quot[QW-1:DW-1]));
      result_in = quot[DW-1:0];
      if (sat_in) begin
         result_in = quot[QW-1] ? rrft_pkg::SAT_MIN : rrft_pkg::SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_ff <= prod_in;
         add1_ff <= add_term;
      end
      if (en.s2) begin
         sum_ff <= sum_in;
      end
      if (en.s3) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

@@ design/ray_rigid_frame_transform_core.sv @@
// Channel   Direction  Handshake            Contents
// req_      in         req_tvalid/tready    tuser: func; tdata: pos_x..vel_z
// rsp_      out        rsp_tvalid/tready    tuser: saturated; tdata: new_pos_x..new_vel_z
// csr_      in/out     APB, pready high     rot_row0..2, offset_x..z at 8*index
//
// A ray is taken every cycle while req_tready is high; an output stall can drop it.
// Stages: input register with offset subtract (func 0), 33x18 multipliers, sum of the
// three products, offset (func 1) and the rounding bias, then saturate.
// Reset clears all stage valid bits and loads the identity matrix and a zero offset.
// A stalled output holds each stage that is full; empty stages keep filling.
module ray_rigid_frame_transform_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, 32 bits each from bit 0 up.
   input  logic [rrft_pkg::TDATA_W-1:0]  req_tdata,
   // func.
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, 32 bits each.
   output logic [rrft_pkg::TDATA_W-1:0]  rsp_tdata,
   // saturated.
   output logic                          rsp_tuser,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rrft_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [rrft_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [rrft_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam int unsigned DW = rrft_pkg::DATA_W;
   localparam int unsigned OW = rrft_pkg::OPND_W;
   localparam int unsigned RW = rrft_pkg::ROT_W;

   rrft_pkg::cfg_type      cfg;
   rrft_pkg::stage_en_type en;
   logic                   en0;

   logic [3:0] valid_ff;
   logic [3:0] valid_in;

   logic                  func0_ff;
   logic [2:0][OW-1:0]    pos0_ff;
   logic [2:0][OW-1:0]    pos0_in;
   logic [2:0][OW-1:0]    vel0_ff;
   logic [2:0][OW-1:0]    vel0_in;
   logic [2:0][DW-1:0]    add0_ff;
   logic [2:0][DW-1:0]    add0_in;

   logic [2:0][2:0][RW-1:0] coef;
   logic [5:0][DW-1:0]      lane_result;
   logic [5:0]              lane_sat;

   rrft_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign en.s3      = !valid_ff[3] || rsp_tready;
   assign en.s2      = !valid_ff[2] || en.s3;
   assign en.s1      = !valid_ff[1] || en.s2;
   assign en0        = !valid_ff[0] || en.s1;
   assign req_tready = en0;

   always_comb begin
      valid_in[0] = en0  ? req_tvalid  : valid_ff[0];
      valid_in[1] = en.s1 ? valid_ff[0] : valid_ff[1];
      valid_in[2] = en.s2 ? valid_ff[1] : valid_ff[2];
      valid_in[3] = en.s3 ? valid_ff[2] : valid_ff[3];
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos0_in[i] = {req_tdata[DW*i+DW-1], req_tdata[DW*i +: DW]};
         vel0_in[i] = {req_tdata[DW*(i+3)+DW-1], req_tdata[DW*(i+3) +: DW]};
         add0_in[i] = '0;
         if (req_tuser) begin
            add0_in[i] = cfg.offset[i];
         end else begin
            pos0_in[i] = pos0_in[i] - {cfg.offset[i][DW-1], cfg.offset[i]};
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            coef[i][k] = func0_ff ? cfg.rot_row[i][RW*k +: RW]
                                  : cfg.rot_row[k][RW*i +: RW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         func0_ff <= req_tuser;
         pos0_ff  <= pos0_in;
         vel0_ff  <= vel0_in;
         add0_ff  <= add0_in;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      rrft_lane u_pos_lane (
         .clock    (clock),
         .en       (en),
         .opnd     (pos0_ff),
         .coef     (coef[i]),
         .add_term (add0_ff[i]),
         .result   (lane_result[i]),
         .sat      (lane_sat[i])
      );
      rrft_lane u_vel_lane (
         .clock    (clock),
         .en       (en),
         .opnd     (vel0_ff),
         .coef     (coef[i]),
         .add_term ('0),
         .result   (lane_result[i+3]),
         .sat      (lane_sat[i+3])
      );
   end

   assign rsp_tvalid = valid_ff[3];
   assign rsp_tdata  = lane_result;
   assign rsp_tuser  = |lane_sat;

`ifndef SYNTHESIS
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !rsp_tready |-> !req_tready)
      else $error("full pipeline did not stall the input");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && !en.s2 |=> valid_ff[1])
      else $error("stalled multiply stage lost its beat");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && !$past(valid_ff[3]) |-> $past(valid_ff[2]))
      else $error("output beat appeared without a sum stage beat");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && lane_sat[0] |->
         (lane_result[0] == rrft_pkg::SAT_MAX || lane_result[0] == rrft_pkg::SAT_MIN))
      else $error("saturated lane holds an unclamped value");
`endif

endmodule
